// ===== hw/rtl/drld_pkg.sv =====
// Shared types and codes for the data run list decoder.
// No dependencies; imported by drld_parser and data_run_list_decoder.
package drld_pkg;

  // Stop reason codes carried with each result word.
  localparam logic [1:0] STOP_ZERO_HDR = 2'd0;
  localparam logic [1:0] STOP_CLEAN    = 2'd1;
  localparam logic [1:0] STOP_CUT      = 2'd2;

  // One parser step's outcome.
  typedef struct packed {
    logic        produced;
    logic        run_valid;
    logic [63:0] run_cluster;
    logic [63:0] run_length;
    logic        list_done;
    logic [1:0]  stop_reason;
  } drld_res_t;

endpackage

// ===== hw/rtl/drld_parser.sv =====
// Run list parser: phase tracking, field gathering, cluster accumulation.
// Depends on drld_pkg. Result is combinational from the current byte and state.
module drld_parser
  import drld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output drld_res_t  res_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [3:0]  off_left_q, off_left_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  off_width_q, off_width_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] off_acc_q, off_acc_d;
  logic [63:0] cluster_q, cluster_d;

  // OR the byte into lane pos; lanes past eight are dropped.
  function automatic logic [63:0] gather(input logic [63:0] acc, input logic [3:0] pos,
                                         input logic [7:0] b);
    logic [63:0] r;
    r = acc;
    for (int j = 0; j < 8; j++) begin
      if (pos == 4'(j)) begin
        r[8*j +: 8] = r[8*j +: 8] | b;
      end
    end
    return r;
  endfunction

  // Sign extend a 1..7 byte offset; wider or empty fields pass as is.
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] w);
    logic [63:0] r;
    logic        sgn;
    r   = v;
    sgn = 1'b0;
    for (int k = 1; k < 8; k++) begin
      if (w == 4'(k)) begin
        sgn = v[8*k-1];
      end
    end
    for (int j = 1; j < 8; j++) begin
      if (sgn && (4'(j) >= w)) begin
        r[8*j +: 8] = 8'hFF;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic        finished;
    logic        end_list;
    logic [1:0]  end_phase;
    logic [63:0] sum;
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    off_left_d  = off_left_q;
    pos_d       = pos_q;
    off_width_d = off_width_q;
    len_acc_d   = len_acc_q;
    off_acc_d   = off_acc_q;
    cluster_d   = cluster_q;
    finished    = 1'b0;
    end_list    = 1'b0;
    end_phase   = PH_HEADER;
    res_o       = '0;

    case (phase_q)
      PH_HEADER: begin
        if (byte_i == 8'h00) begin
          res_o.produced    = 1'b1;
          res_o.list_done   = 1'b1;
          res_o.stop_reason = STOP_ZERO_HDR;
          end_list          = 1'b1;
          end_phase         = last_i ? PH_HEADER : PH_DRAIN;
        end else if (last_i) begin
          res_o.produced    = 1'b1;
          res_o.list_done   = 1'b1;
          res_o.stop_reason = STOP_CUT;
          end_list          = 1'b1;
        end else begin
          len_left_d  = byte_i[3:0];
          off_left_d  = byte_i[7:4];
          off_width_d = byte_i[7:4];
          pos_d       = '0;
          len_acc_d   = '0;
          off_acc_d   = '0;
          phase_d     = (byte_i[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
        end
      end
      PH_LENGTH: begin
        len_acc_d  = gather(len_acc_q, pos_q, byte_i);
        len_left_d = len_left_q - 4'd1;
        pos_d      = pos_q + 4'd1;
        if (len_left_d == 4'd0) begin
          pos_d = '0;
          if (off_left_q == 4'd0) begin
            finished = 1'b1;
          end else begin
            phase_d = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        off_acc_d  = gather(off_acc_q, pos_q, byte_i);
        off_left_d = off_left_q - 4'd1;
        pos_d      = pos_q + 4'd1;
        if (off_left_d == 4'd0) begin
          finished = 1'b1;
        end
      end
      default: begin
        // draining after a zero header, until the final byte
        if (last_i) begin
          end_list = 1'b1;
        end
      end
    endcase

    sum = cluster_q + sext(off_acc_d, off_width_q);
    if (finished) begin
      res_o.produced    = 1'b1;
      res_o.run_valid   = 1'b1;
      res_o.run_cluster = sum;
      res_o.run_length  = len_acc_d;
      res_o.list_done   = last_i;
      res_o.stop_reason = last_i ? STOP_CLEAN : STOP_ZERO_HDR;
      if (last_i) begin
        end_list = 1'b1;
      end else begin
        cluster_d = sum;
        phase_d   = PH_HEADER;
        pos_d     = '0;
      end
    end else if (last_i && (phase_q == PH_LENGTH || phase_q == PH_OFFSET)) begin
      res_o.produced    = 1'b1;
      res_o.list_done   = 1'b1;
      res_o.stop_reason = STOP_CUT;
      end_list          = 1'b1;
    end

    if (end_list) begin
      phase_d     = end_phase;
      len_left_d  = '0;
      off_left_d  = '0;
      pos_d       = '0;
      off_width_d = '0;
      len_acc_d   = '0;
      off_acc_d   = '0;
      cluster_d   = '0;
    end

    if (!step_i) begin
      res_o.produced = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_left_q  <= '0;
      off_left_q  <= '0;
      pos_q       <= '0;
      off_width_q <= '0;
      len_acc_q   <= '0;
      off_acc_q   <= '0;
      cluster_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      off_left_q  <= off_left_d;
      pos_q       <= pos_d;
      off_width_q <= off_width_d;
      len_acc_q   <= len_acc_d;
      off_acc_q   <= off_acc_d;
      cluster_q   <= cluster_d;
    end
  end

endmodule

// ===== hw/rtl/data_run_list_decoder.sv =====
// Top level of the data run list decoder: input register, parser, result register.
// Depends on drld_pkg and drld_parser.
//
// Usage:
//   Slave side takes one run list byte per word: tdata[7:0] is the byte, tlast
//   marks the final byte of the list. Master side gives at most one word per
//   input byte: tdata carries the run's absolute start cluster and length,
//   tuser says whether a run is present and why the list stopped, tlast marks
//   the last word of the list.
//   Each nonzero header byte opens a run; its low nibble counts length bytes
//   and its high nibble signed offset bytes. The offset is added, mod 2^64, to the
//   running cluster, which restarts at zero for every new list.
//   Pipeline: a taken byte passes the input register and the result register,
//   two register stages with one 64-bit add between them.
//   Throughput: one byte per cycle, sustained, as long as the receiver takes
//   words; the held byte steps only when the result register is free or drains.
//   Stall: while the result register holds an untaken word, the held byte does
//   not step (even one that yields no word) and tready drops; the input
//   register and result register each hold one word, so nothing is lost.
//   Reset: parser returns to expecting a header with a zero running cluster;
//   both stages empty.
module data_run_list_decoder
  import drld_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: [7:0] data_byte; tlast: last_byte
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  // tdata: [63:0] run_cluster, [127:64] run_length
  // tuser: [0] run_valid, [2:1] stop_reason; tlast: list_done
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic        out_valid_q;
  logic        out_run_valid_q;
  logic [63:0] out_cluster_q;
  logic [63:0] out_length_q;
  logic        out_done_q;
  logic [1:0]  out_reason_q;

  drld_res_t res;
  logic      step;
  logic      out_free;

  // The held byte may step when the result register can take a word.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  drld_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.produced) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.produced) begin
      out_run_valid_q <= res.run_valid;
      out_cluster_q   <= res.run_cluster;
      out_length_q    <= res.run_length;
      out_done_q      <= res.list_done;
      out_reason_q    <= res.stop_reason;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_length_q, out_cluster_q};
  assign m_axis_tuser  = {out_reason_q, out_run_valid_q};
  assign m_axis_tlast  = out_done_q;

  // A word with no run always closes the list.
  a_norun_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_run_valid_q) |-> out_done_q)
    else $error("run-less word without list_done");

  // A run word reports a clean stop exactly when it ends the list.
  a_run_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_run_valid_q) |->
      ((out_done_q && out_reason_q == STOP_CLEAN) ||
       (!out_done_q && out_reason_q == STOP_ZERO_HDR)))
    else $error("run word with inconsistent stop reason");

  // A run-less word carries zero cluster and length.
  a_norun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_run_valid_q) |-> (out_cluster_q == '0 && out_length_q == '0))
    else $error("run-less word with nonzero payload");

  // The parser never produces while the result register is blocked.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !res.produced)
    else $error("result overwritten while stalled");

  // Backpressure only when a byte is held.
  a_ready_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("tready low with empty input register");

endmodule

// ===== tb/data_run_list_decoder_tb.sv =====
// Self-checking testbench for data_run_list_decoder: drives run list bytes and checks
// every result word against a cycle-free decoder model kept in this file.
// Depends on drld_pkg and the data_run_list_decoder RTL.
`timescale 1ns / 100ps

module data_run_list_decoder_tb
  import drld_pkg::*;
();

  // One expected result word, with the fields of the master side.
  typedef struct packed {
    logic        run_valid;
    logic [63:0] cluster;
    logic [63:0] length;
    logic        done;
    logic [1:0]  reason;
  } run_word_t;

  // Decoder scan phase.
  typedef enum logic [1:0] {
    EXPECT_HDR = 2'd0,
    TAKE_LEN   = 2'd1,
    TAKE_OFF   = 2'd2,
    DRAIN      = 2'd3
  } scan_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Decoder model state.
  scan_e       scan = EXPECT_HDR;
  logic [3:0]  len_left = '0;
  logic [3:0]  off_left = '0;
  logic [3:0]  pos = '0;
  logic [3:0]  off_bytes = '0;
  logic [63:0] len_acc = '0;
  logic [63:0] off_acc = '0;
  logic [63:0] cluster = '0;

  run_word_t pending_runs[$];
  int        mismatches = 0;
  int        sent_bytes = 0;
  bit        steady = 1'b0;  // no idling on either side while set

  data_run_list_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // A list ends: everything clears, the running cluster restarts at zero.
  task automatic clear_list(input scan_e next_scan);
    scan      = next_scan;
    len_left  = '0;
    off_left  = '0;
    pos       = '0;
    off_bytes = '0;
    len_acc   = '0;
    off_acc   = '0;
    cluster   = '0;
  endtask

  // Little-endian gather; bytes past the eighth are dropped.
  function automatic logic [63:0] gather_byte(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] r;
    r = acc;
    if (pos < 4'd8)
      r = acc | (64'(b) << (pos * 8));
    pos = pos + 4'd1;
    return r;
  endfunction

  task automatic push_end(input logic [1:0] reason);
    run_word_t w;
    w = '{run_valid: 1'b0, cluster: '0, length: '0, done: 1'b1, reason: reason};
    pending_runs = {pending_runs, w};
  endtask

  // Steps the model by one accepted byte and queues the word it yields, if any.
  task automatic decode_byte(input logic [7:0] b, input logic l);
    logic        run_done;
    logic [63:0] delta;
    run_word_t   w;
    run_done = 1'b0;
    case (scan)
      EXPECT_HDR: begin
        if (b == 8'h00) begin
          push_end(STOP_ZERO_HDR);
          clear_list(l ? EXPECT_HDR : DRAIN);
        end else if (l) begin
          // a header as the final byte leaves its run unfinished
          push_end(STOP_CUT);
          clear_list(EXPECT_HDR);
        end else begin
          len_left  = b[3:0];
          off_left  = b[7:4];
          off_bytes = b[7:4];
          pos       = '0;
          len_acc   = '0;
          off_acc   = '0;
          scan      = (b[3:0] != 4'd0) ? TAKE_LEN : TAKE_OFF;
        end
      end
      TAKE_LEN: begin
        len_acc  = gather_byte(len_acc, b);
        len_left = len_left - 4'd1;
        if (len_left == 4'd0) begin
          pos = '0;
          if (off_left == 4'd0)
            run_done = 1'b1;
          else
            scan = TAKE_OFF;
        end
      end
      TAKE_OFF: begin
        off_acc  = gather_byte(off_acc, b);
        off_left = off_left - 4'd1;
        if (off_left == 4'd0)
          run_done = 1'b1;
      end
      default: begin
        // draining after a zero header; the final byte reopens
        if (l)
          clear_list(EXPECT_HDR);
      end
    endcase

    if (scan == TAKE_LEN || scan == TAKE_OFF || run_done) begin
      if (run_done) begin
        // sign extension only for 1..7 offset bytes
        delta = off_acc;
        if (off_bytes >= 4'd1 && off_bytes <= 4'd7 && off_acc[off_bytes * 8 - 1])
          delta = off_acc | (~64'd0 << (off_bytes * 8));
        cluster = cluster + delta;
        w = '{run_valid: 1'b1, cluster: cluster, length: len_acc, done: l,
              reason: l ? STOP_CLEAN : STOP_ZERO_HDR};
        pending_runs = {pending_runs, w};
        if (l) begin
          clear_list(EXPECT_HDR);
        end else begin
          scan = EXPECT_HDR;
          pos  = '0;
        end
      end else if (l) begin
        push_end(STOP_CUT);
        clear_list(EXPECT_HDR);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random backpressure and the result check
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk_i) begin : check_words
    run_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: word with none expected: cluster %h length %h user %b last %b",
                 $time, m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser,
                 m_axis_tlast);
        mismatches++;
      end else begin
        want = pending_runs.pop_front();
        if (m_axis_tuser[0] !== want.run_valid) begin
          $display("%0t: run_valid expected %b actual %b", $time, want.run_valid,
                   m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata[63:0] !== want.cluster) begin
          $display("%0t: run_cluster expected %h actual %h", $time, want.cluster,
                   m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[127:64] !== want.length) begin
          $display("%0t: run_length expected %h actual %h", $time, want.length,
                   m_axis_tdata[127:64]);
          mismatches++;
        end
        if (m_axis_tlast !== want.done) begin
          $display("%0t: list_done expected %b actual %b", $time, want.done,
                   m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[2:1] !== want.reason) begin
          $display("%0t: stop_reason expected %0d actual %0d", $time, want.reason,
                   m_axis_tuser[2:1]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Slave side
  // ---------------------------------------------------------------------------

  // Enters and leaves at a falling edge; tvalid stays high between back-to-back words.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!steady && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready)
      @(posedge clk_i);
    decode_byte(b, l);
    sent_bytes++;
    @(negedge clk_i);
  endtask

  // Content byte, leaning on sign and extreme values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A run list: a few runs, then a zero header (maybe with trailing bytes) or a
  // final run that carries tlast. A broken list is cut at a random byte.
  task automatic send_run_list(input bit broken);
    logic [7:0] seq[$];
    logic [3:0] lo, hi;
    int         runs, n, cut, i;
    runs = $urandom_range(0, 5);
    for (i = 0; i < runs; i++) begin
      lo = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
      hi = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
      if (lo == 4'd0 && hi == 4'd0)
        lo = 4'd1;
      seq = {seq, {hi, lo}};
      n = int'(lo) + int'(hi);
      repeat (n) seq = {seq, pick_byte()};
    end
    if (runs == 0 || $urandom_range(0, 99) < 60) begin
      seq = {seq, 8'h00};
      n = $urandom_range(0, 3);
      repeat (n) seq = {seq, 8'($urandom_range(0, 255))};
    end
    cut = broken ? $urandom_range(0, seq.size() - 1) : seq.size() - 1;
    for (i = 0; i <= cut; i++)
      send_byte(seq[i], i == cut);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // run with one length and one negative offset byte, then a zero-offset run
    send_byte(8'h11, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h05, 1'b0);
    // zero header mid-list, then bytes drained up to the final one
    send_byte(8'h00, 1'b0); send_byte(8'h33, 1'b0); send_byte(8'hC4, 1'b1);
    // nonzero header as the final byte
    send_byte(8'h21, 1'b1);
    // zero header as the final byte
    send_byte(8'h00, 1'b1);
    // run finished on the final byte, offset only
    send_byte(8'h10, 1'b0); send_byte(8'h7F, 1'b1);
    // final byte in the middle of a run
    send_byte(8'h22, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b1);
    // eight offset bytes, top bit set: no sign extension
    send_byte(8'h80, 1'b0);
    repeat (7) send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  task automatic test_random_lists();
    while (sent_bytes < 1650) begin
      steady = (sent_bytes >= 500 && sent_bytes < 800);
      send_run_list($urandom_range(0, 99) < 20);
    end
    steady = 1'b0;
  endtask

  // Unstructured bytes with scattered tlast, ending on one to close the list.
  task automatic test_noise();
    repeat (150) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_lists();
    test_noise();

    s_axis_tvalid <= 1'b0;
    while (pending_runs.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/drld_pkg.sv
hw/rtl/drld_parser.sv
hw/rtl/data_run_list_decoder.sv
tb/data_run_list_decoder_tb.sv
